// ===== src/ethl4p_pkg.sv =====
package ethl4p_pkg;

	localparam int unsigned POS_W    = 16;
	localparam int unsigned DATA_W   = 144;
	localparam int unsigned RESULT_W = 138;

	localparam logic [16:0] MAX_FRAME_LEN = 17'd65535;

	localparam logic [POS_W-1:0] POS_MAX       = 16'hFFFF;
	localparam logic [POS_W-1:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [POS_W-1:0] IP_MIN_END    = 16'd34;
	localparam logic [POS_W-1:0] POS_KIND_HI   = 16'd12;
	localparam logic [POS_W-1:0] POS_KIND_LO   = 16'd13;
	localparam logic [POS_W-1:0] POS_IHL       = 16'd14;
	localparam logic [POS_W-1:0] POS_PROTO     = 16'd23;
	localparam logic [POS_W-1:0] POS_SRC_FIRST = 16'd26;
	localparam logic [POS_W-1:0] POS_SRC_LAST  = 16'd29;
	localparam logic [POS_W-1:0] POS_DST_FIRST = 16'd30;
	localparam logic [POS_W-1:0] POS_DST_LAST  = 16'd33;
	localparam logic [POS_W-1:0] PORT_BYTES    = 16'd4;
	localparam logic [POS_W-1:0] TCP_FLAG_OFS  = 16'd13;
	localparam logic [POS_W-1:0] TCP_MIN_BYTES = 16'd14;
	localparam logic [3:0]       IHL_MIN       = 4'd5;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;

	localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
	localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;
	localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;

	typedef enum logic [1:0] {
		FC_IPV4  = 2'd0,
		FC_IPV6  = 2'd1,
		FC_ARP   = 2'd2,
		FC_OTHER = 2'd3
	} frame_class_t;

	typedef enum logic [2:0] {
		PC_TCP   = 3'd0,
		PC_UDP   = 3'd1,
		PC_ICMP  = 3'd2,
		PC_OTHER = 3'd3,
		PC_NONE  = 3'd4
	} proto_class_t;

endpackage

// ===== src/ethernet_ipv4_l4_header_parser.sv =====
// A frame's last byte is registered in the input stage, then its result in the result slot.
// Throughput: one byte per cycle, back to back, while the result slot can take a frame's
// result; one result per frame. The result register frees the byte path so only a full,
// stalled result holds up input. Reset (arst_n low, asynchronous): input stage and result
// slot empty, per-frame capture state cleared to zero as at the start of a frame.
module ethernet_ipv4_l4_header_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	// frame stream in
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // [7:0] frame_byte
	input  logic                         s_axis_tlast,   // frame_end
	// parse results out
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [15:0] ether_kind, [17:16] frame_class, [49:18] source_address,
	// [81:50] dest_address, [84:82] proto_class, [100:85] source_port,
	// [116:101] dest_port, [120:117] tcp_flag_bits, [136:121] frame_length,
	// [137] malformed, [143:138] zero
	output logic [ethl4p_pkg::DATA_W-1:0] m_axis_tdata
);
	import ethl4p_pkg::*;

	// Input stage: one registered byte per transaction.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Per-frame capture state.
	logic [POS_W-1:0] pos_q;
	logic [15:0]      kind_q;
	logic [3:0]       hw_q;
	logic [7:0]       proto_q;
	logic [31:0]      src_q;
	logic [31:0]      dst_q;
	logic [31:0]      port_q;
	logic [7:0]       flag_q;

	// Result slot.
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;

	// Stage 1 advances unless it holds a last byte and the result slot is stuck.
	logic s1_move;
	logic out_load;

	assign s1_move       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign out_load      = s1_move && last_s1;
	assign s_axis_tready = !valid_s1 || s1_move;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Capture: state after taking the stage-1 byte.
	logic [15:0]      kind_nx;
	logic [3:0]       hw_nx;
	logic [7:0]       proto_nx;
	logic [31:0]      src_nx;
	logic [31:0]      dst_nx;
	logic [31:0]      port_nx;
	logic [7:0]       flag_nx;
	logic [POS_W-1:0] l4_ofs;  // transport header offset, 14 + IHL*4

	always_comb begin
		kind_nx  = kind_q;
		hw_nx    = hw_q;
		proto_nx = proto_q;
		src_nx   = src_q;
		dst_nx   = dst_q;
		port_nx  = port_q;
		flag_nx  = flag_q;
		if (pos_q == POS_KIND_HI || pos_q == POS_KIND_LO) begin
			kind_nx = {kind_q[7:0], byte_s1};
		end
		if (pos_q == POS_IHL) begin
			hw_nx = byte_s1[3:0];
		end
		if (pos_q == POS_PROTO) begin
			proto_nx = byte_s1;
		end
		if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) begin
			src_nx = {src_q[23:0], byte_s1};
		end
		if (pos_q >= POS_DST_FIRST && pos_q <= POS_DST_LAST) begin
			dst_nx = {dst_q[23:0], byte_s1};
		end
		l4_ofs = ETH_HDR_BYTES + {10'd0, hw_nx, 2'b00};
		// Ports and flags only once the IPv4 addresses are past.
		if (pos_q >= IP_MIN_END) begin
			if (pos_q >= l4_ofs && pos_q < l4_ofs + PORT_BYTES) begin
				port_nx = {port_q[23:0], byte_s1};
			end
			if (pos_q == l4_ofs + TCP_FLAG_OFS) begin
				flag_nx = byte_s1;
			end
		end
	end

	// Classification of the completed frame.
	logic [16:0]       count;
	logic [15:0]       len;
	logic [15:0]       r_kind;
	frame_class_t      r_fclass;
	logic [31:0]       r_src;
	logic [31:0]       r_dst;
	proto_class_t      r_pclass;
	logic [15:0]       r_sport;
	logic [15:0]       r_dport;
	logic [3:0]        r_flags;
	logic              r_bad;
	logic [RESULT_W-1:0] result;

	always_comb begin
		count    = {1'b0, pos_q} + 17'd1;
		len      = (count > MAX_FRAME_LEN) ? MAX_FRAME_LEN[15:0] : count[15:0];
		r_kind   = '0;
		r_fclass = FC_OTHER;
		r_src    = '0;
		r_dst    = '0;
		r_pclass = PC_NONE;
		r_sport  = '0;
		r_dport  = '0;
		r_flags  = '0;
		r_bad    = 1'b0;
		if (count < {1'b0, ETH_HDR_BYTES}) begin
			r_bad = 1'b1;
		end else begin
			r_kind = kind_nx;
			if (kind_nx == ETYPE_IPV4) begin
				r_fclass = FC_IPV4;
			end else if (kind_nx == ETYPE_IPV6) begin
				r_fclass = FC_IPV6;
			end else if (kind_nx == ETYPE_ARP) begin
				r_fclass = FC_ARP;
			end else begin
				r_fclass = FC_OTHER;
			end
			if (r_fclass == FC_IPV4) begin
				if (count < {1'b0, IP_MIN_END} || hw_nx < IHL_MIN) begin
					r_bad = 1'b1;
				end else begin
					r_src = src_nx;
					r_dst = dst_nx;
					if (proto_nx == PROTO_NUM_TCP) begin
						r_pclass = PC_TCP;
						if (count < {1'b0, l4_ofs + TCP_MIN_BYTES}) begin
							r_bad = 1'b1;
						end else begin
							r_sport = port_nx[31:16];
							r_dport = port_nx[15:0];
							// SYN, ACK, FIN, RST from the raw flag byte
							r_flags = {flag_nx[2], flag_nx[0], flag_nx[4], flag_nx[1]};
						end
					end else if (proto_nx == PROTO_NUM_UDP) begin
						r_pclass = PC_UDP;
						if (count < {1'b0, l4_ofs + PORT_BYTES}) begin
							r_bad = 1'b1;
						end else begin
							r_sport = port_nx[31:16];
							r_dport = port_nx[15:0];
						end
					end else if (proto_nx == PROTO_NUM_ICMP) begin
						r_pclass = PC_ICMP;
					end else begin
						r_pclass = PC_OTHER;
					end
				end
			end
		end
		result = {r_bad, len, r_flags, r_dport, r_sport, r_pclass, r_dst, r_src,
		          r_fclass, r_kind};
	end

	// Control and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			kind_q      <= '0;
			hw_q        <= '0;
			proto_q     <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			port_q      <= '0;
			flag_q      <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_move) begin
				if (last_s1) begin
					// frame done: start the next one clean
					pos_q   <= '0;
					kind_q  <= '0;
					hw_q    <= '0;
					proto_q <= '0;
					src_q   <= '0;
					dst_q   <= '0;
					port_q  <= '0;
					flag_q  <= '0;
				end else begin
					pos_q   <= (pos_q != POS_MAX) ? pos_q + 16'd1 : pos_q;
					kind_q  <= kind_nx;
					hw_q    <= hw_nx;
					proto_q <= proto_nx;
					src_q   <= src_nx;
					dst_q   <= dst_nx;
					port_q  <= port_nx;
					flag_q  <= flag_nx;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (out_load) begin
			out_data_q <= {{(DATA_W-RESULT_W){1'b0}}, result};
		end
	end

endmodule

// ===== bench/hdr_parse_sb_pkg.sv =====
package hdr_parse_sb_pkg;

	import ethl4p_pkg::*;

	// flag bit positions inside the TCP flags byte
	localparam int unsigned TCP_FIN_BIT = 0;
	localparam int unsigned TCP_SYN_BIT = 1;
	localparam int unsigned TCP_RST_BIT = 2;
	localparam int unsigned TCP_ACK_BIT = 4;

	// result word, msb first so a cast from m_axis_tdata unpacks it
	typedef struct packed {
		logic [5:0]   pad;
		logic         malformed;
		logic [15:0]  frame_length;
		logic [3:0]   tcp_flag_bits;
		logic [15:0]  dest_port;
		logic [15:0]  source_port;
		proto_class_t proto_class;
		logic [31:0]  dest_address;
		logic [31:0]  source_address;
		frame_class_t frame_class;
		logic [15:0]  ether_kind;
	} parse_result_t;

	class header_scoreboard;

		logic [15:0] byte_pos;
		logic [15:0] kind_reg;
		logic [3:0]  ihl_reg;
		logic [7:0]  proto_reg;
		logic [31:0] src_reg;
		logic [31:0] dst_reg;
		logic [31:0] ports_reg;
		logic [7:0]  flags_reg;

		parse_result_t expected_q[$];
		int unsigned fails;

		function new();
			clear_frame();
			fails = 0;
		endfunction

		function void clear_frame();
			byte_pos  = '0;
			kind_reg  = '0;
			ihl_reg   = '0;
			proto_reg = '0;
			src_reg   = '0;
			dst_reg   = '0;
			ports_reg = '0;
			flags_reg = '0;
		endfunction

		// one accepted frame byte; a frame end queues the expected header summary
		function void note_byte(logic [7:0] b, logic last);
			parse_result_t want;
			logic [16:0] total;
			logic [16:0] l4_start;
			logic [16:0] pos;

			pos = {1'b0, byte_pos};
			if (pos == 17'd12 || pos == 17'd13)
				kind_reg = {kind_reg[7:0], b};
			if (pos == 17'd14)
				ihl_reg = b[3:0];
			if (pos == 17'd23)
				proto_reg = b;
			if (pos >= 17'd26 && pos <= 17'd29)
				src_reg = {src_reg[23:0], b};
			if (pos >= 17'd30 && pos <= 17'd33)
				dst_reg = {dst_reg[23:0], b};
			l4_start = 17'd14 + {11'd0, ihl_reg, 2'b00};
			if (pos >= 17'd34) begin
				if (pos >= l4_start && pos < l4_start + 17'd4)
					ports_reg = {ports_reg[23:0], b};
				if (pos == l4_start + 17'd13)
					flags_reg = b;
			end
			total = pos + 17'd1;
			if (byte_pos != 16'hFFFF)
				byte_pos = byte_pos + 16'd1;
			if (!last)
				return;

			want = '0;
			want.frame_class = FC_OTHER;
			want.proto_class = PC_NONE;
			want.frame_length = (total > MAX_FRAME_LEN) ? 16'hFFFF : total[15:0];
			if (total < 17'd14) begin
				want.malformed = 1'b1;
			end else begin
				want.ether_kind = kind_reg;
				case (kind_reg)
					ETYPE_IPV4: want.frame_class = FC_IPV4;
					ETYPE_IPV6: want.frame_class = FC_IPV6;
					ETYPE_ARP:  want.frame_class = FC_ARP;
					default:    want.frame_class = FC_OTHER;
				endcase
				if (want.frame_class == FC_IPV4) begin
					if (total < 17'd34 || ihl_reg < 4'd5) begin
						want.malformed = 1'b1;
					end else begin
						want.source_address = src_reg;
						want.dest_address   = dst_reg;
						if (proto_reg == PROTO_NUM_TCP) begin
							want.proto_class = PC_TCP;
							if (total < l4_start + 17'd14) begin
								want.malformed = 1'b1;
							end else begin
								want.source_port = ports_reg[31:16];
								want.dest_port   = ports_reg[15:0];
								want.tcp_flag_bits = {flags_reg[TCP_RST_BIT],
									flags_reg[TCP_FIN_BIT], flags_reg[TCP_ACK_BIT],
									flags_reg[TCP_SYN_BIT]};
							end
						end else if (proto_reg == PROTO_NUM_UDP) begin
							want.proto_class = PC_UDP;
							if (total < l4_start + 17'd4) begin
								want.malformed = 1'b1;
							end else begin
								want.source_port = ports_reg[31:16];
								want.dest_port   = ports_reg[15:0];
							end
						end else if (proto_reg == PROTO_NUM_ICMP) begin
							want.proto_class = PC_ICMP;
						end else begin
							want.proto_class = PC_OTHER;
						end
					end
				end
			end
			expected_q.push_back(want);
			clear_frame();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got,
			longint unsigned at);
			if (got !== want) begin
				$display("%0d ns: %s expected %0h got %0h", at, name, want, got);
				fails++;
			end
		endfunction

		function void check_result(logic [DATA_W-1:0] data, longint unsigned at);
			parse_result_t got;
			parse_result_t want;

			got = parse_result_t'(data);
			if (expected_q.size() == 0) begin
				$display("%0d ns: result with no frame pending, expected none got %h", at, data);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("ether_kind", 32'(want.ether_kind), 32'(got.ether_kind), at);
			compare_field("frame_class", 32'(want.frame_class), 32'(got.frame_class), at);
			compare_field("source_address", want.source_address, got.source_address, at);
			compare_field("dest_address", want.dest_address, got.dest_address, at);
			compare_field("proto_class", 32'(want.proto_class), 32'(got.proto_class), at);
			compare_field("source_port", 32'(want.source_port), 32'(got.source_port), at);
			compare_field("dest_port", 32'(want.dest_port), 32'(got.dest_port), at);
			compare_field("tcp_flag_bits", 32'(want.tcp_flag_bits), 32'(got.tcp_flag_bits),
				at);
			compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length), at);
			compare_field("malformed", 32'(want.malformed), 32'(got.malformed), at);
			compare_field("pad", 32'(want.pad), 32'(got.pad), at);
		endfunction

		function void check_drained(longint unsigned at);
			if (expected_q.size() != 0) begin
				$display("%0d ns: %0d results expected, 0 received", at, expected_q.size());
				fails++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function int unsigned fail_count();
			return fails;
		endfunction

	endclass

endpackage

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ethl4p_pkg::*;
	import hdr_parse_sb_pkg::*;

	// hard stop for the whole run
	localparam int unsigned CYCLE_LIMIT    = 2_000_000;
	// margin after the last result, before the final drain check
	localparam int unsigned DRAIN_CYCLES   = 8;
	// random traffic per idle phase: stop once both are reached
	localparam int unsigned PHASE_BYTES    = 70;
	localparam int unsigned PHASE_FRAMES   = 2;

	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_kind_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] frame_byte
	logic        s_axis_tlast  = 1'b0;    // frame_end

	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DATA_W-1:0]   m_axis_tdata;    // header summary, see parse_result_t

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned bytes_sent     = 0;
	int unsigned cycle_count    = 0;

	header_scoreboard frame_sb = new();

	ethernet_ipv4_l4_header_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random backpressure at the current phase's rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: values read here are the ones the edge sampled, since every
	// tb drive and every DUT register update lands in the NBA region
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				frame_sb.note_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				frame_sb.check_result(m_axis_tdata, $time);
		end
	end

	// one byte transaction, preceded by random idle cycles
	task automatic push_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	// background fill, then EtherType, IHL nibble and protocol placed on top;
	// the version nibble keeps whatever the fill gave it
	task automatic send_frame(input logic [15:0] etype, input logic [3:0] ihl,
		input logic [7:0] proto, input int unsigned len, input fill_kind_t fill);
		logic [7:0] b;
		for (int unsigned i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom);
			endcase
			case (i)
				12:      b = etype[15:8];
				13:      b = etype[7:0];
				14:      b[3:0] = ihl;
				23:      b = proto;
				default: ;
			endcase
			push_byte(b, i == len - 1);
		end
	endtask

	// mostly IPv4 with random content; frames also land on the
	// truncation boundaries, odd IHL values, other EtherTypes
	task automatic send_random_frame();
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		int unsigned l4_start;
		int unsigned need;
		int unsigned len;
		int unsigned r;

		r = $urandom_range(99);
		if (r < 70)      etype = ETYPE_IPV4;
		else if (r < 78) etype = ETYPE_IPV6;
		else if (r < 86) etype = ETYPE_ARP;
		else             etype = 16'($urandom);

		r = $urandom_range(99);
		if (r < 75)      ihl = 4'd5;
		else if (r < 90) ihl = 4'($urandom_range(6, 15));
		else             ihl = 4'($urandom_range(0, 4));

		r = $urandom_range(99);
		if (r < 40)      proto = PROTO_NUM_TCP;
		else if (r < 70) proto = PROTO_NUM_UDP;
		else if (r < 80) proto = PROTO_NUM_ICMP;
		else             proto = 8'($urandom);

		l4_start = 14 + ihl * 4;
		if (proto == PROTO_NUM_TCP)      need = l4_start + 14;
		else if (proto == PROTO_NUM_UDP) need = l4_start + 4;
		else                             need = 34;
		if (need < 34)
			need = 34;

		r = $urandom_range(99);
		if (r < 65) begin
			len = need + $urandom_range(0, 8);
		end else if (r < 85) begin
			case ($urandom_range(5))
				0:       len = need - 1;
				1:       len = need;
				2:       len = 33;
				3:       len = 34;
				4:       len = 13;
				default: len = 14;
			endcase
		end else begin
			len = $urandom_range(1, need + 4);
		end
		send_frame(etype, ihl, proto, len, FILL_RANDOM);
	endtask

	// sender holds off until every queued result is out
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_sb.pending() != 0)
			@(posedge clk);
	endtask

	// idle phases: none, sender 59%, receiver 59%, both 17%
	int unsigned phase_send[4]  = '{0, 59, 0, 17};
	int unsigned phase_stall[4] = '{0, 0, 59, 17};

	initial begin
		int unsigned start_bytes;
		int unsigned frames;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = phase_send[ph];
			recv_stall_pct = phase_stall[ph];

			if (ph == 0) begin
				// short frames: below the Ethernet header, exactly at it
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_TCP, 1, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_TCP, 13, FILL_ONES);
				send_frame(16'h1234, 4'd5, PROTO_NUM_TCP, 14, FILL_RANDOM);
				// non-IPv4 classes and the EtherType extremes
				send_frame(ETYPE_IPV6, 4'd5, PROTO_NUM_TCP, 60, FILL_RANDOM);
				send_frame(ETYPE_ARP, 4'd5, PROTO_NUM_UDP, 42, FILL_RANDOM);
				send_frame(16'hFFFF, 4'd5, PROTO_NUM_TCP, 60, FILL_ONES);
				send_frame(16'h0000, 4'd5, PROTO_NUM_TCP, 60, FILL_ZERO);
				// IPv4 cut before the addresses end, then just long enough
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_TCP, 33, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_ICMP, 34, FILL_RANDOM);
				// IHL below the minimum
				send_frame(ETYPE_IPV4, 4'd4, PROTO_NUM_TCP, 60, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd0, PROTO_NUM_UDP, 60, FILL_RANDOM);
				// TCP one byte short of the flags, then complete, all flags, none
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_TCP, 47, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_TCP, 48, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_TCP, 48, FILL_ONES);
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_TCP, 48, FILL_ZERO);
				// UDP one byte short of the ports, then complete
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_UDP, 37, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd5, PROTO_NUM_UDP, 38, FILL_RANDOM);
				// other protocols need nothing past the addresses
				send_frame(ETYPE_IPV4, 4'd5, 8'hFF, 60, FILL_ONES);
				send_frame(ETYPE_IPV4, 4'd5, 8'h00, 34, FILL_ZERO);
				// options: transport header pushed out to the largest offset, then by one option word
				send_frame(ETYPE_IPV4, 4'd15, PROTO_NUM_TCP, 88, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd15, PROTO_NUM_UDP, 77, FILL_RANDOM);
				send_frame(ETYPE_IPV4, 4'd6, PROTO_NUM_TCP, 62, FILL_RANDOM);
			end

			start_bytes = bytes_sent;
			frames = 0;
			while (bytes_sent - start_bytes < PHASE_BYTES || frames < PHASE_FRAMES) begin
				send_random_frame();
				frames++;
			end
			wait_results_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		frame_sb.check_drained($time);
		if (frame_sb.fail_count() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
